// File: design/fdx_pkg.sv
// fdx_pkg: shared types and constants for the framed byte deframer
// no dependencies; imported by the frame store and the top level
`timescale 1ns / 1ps
`default_nettype none

package fdx_pkg;

	// framing bytes
	localparam logic [7:0] SOH_BYTE = 8'h01;
	localparam logic [7:0] STX_BYTE = 8'h02;
	localparam logic [7:0] EOT_BYTE = 8'h04;

	// shortest legal frame: SOH, length, STX, one body byte, EOT
	localparam logic [7:0] MIN_HDR_LEN = 8'd5;

	// frame byte that holds the message type, first payload byte follows it
	localparam int TYPE_POS = 4;
	localparam int PAYLOAD_POS = 5;

	// register indexes on the configuration port
	localparam logic REG_MIN_LEN = 1'b0;
	localparam logic REG_MAX_LEN = 1'b1;

	// port enables for the frame store
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} fdx_mem_ctl_t;

endpackage

`default_nettype wire

// File: design/fdx_frame_store.sv
// fdx_frame_store: single-port-write, single-port-read frame byte memory
// read data is registered and holds while rd_en is low; depends on fdx_pkg
`timescale 1ns / 1ps
`default_nettype none

module fdx_frame_store #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  wire                        clk,
	input  wire fdx_pkg::fdx_mem_ctl_t ctl,
	input  wire  [AW-1:0]              wr_addr,
	input  wire  [7:0]                 wr_data,
	input  wire  [AW-1:0]              rd_addr,
	output logic [7:0]                 rd_data
);
	import fdx_pkg::*;

	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port with enable
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: design/framed_byte_deframer_xor_check_unit.sv
// framed_byte_deframer_xor_check_unit: SOH/length/STX/body/EOT deframer with XOR check
// depends on fdx_pkg and fdx_frame_store
`timescale 1ns / 1ps
`default_nettype none

// Usage
// Received bytes enter on the s_ stream, one per transaction. The block hunts for
// SOH, checks the length byte against min_frame_len / max_frame_len (APB registers
// at 0x0 and 0x4), expects STX, stores the whole frame in an internal memory and at
// EOT requires the XOR of all bytes before the checksum byte to match it.
// A good frame is replayed from the memory on the m_ stream: one transaction per
// payload byte (at least one), each carrying the type byte, payload length and
// byte index, with m_tlast on the final one.
// Throughput: one input byte per cycle while a frame is received. After a good EOT
// input stalls until max(1, payload_len) reads issue, one read per cycle unless the
// receiver stalls; the first result shows after the emit phase and its first read.
// The read data register of the memory is the output register, so a stalled
// receiver simply stops further reads; input resumes once the last read issues,
// even while that last result still waits.
// Reset returns to hunting for SOH with both registers at their defaults
// (8 and 64); the frame memory is not cleared and needs no clearing pass.
module framed_byte_deframer_xor_check_unit #(
	parameter int MAX_FRAME = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	// input byte stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
	// result stream
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [7:0] msg_type, [13:8] payload_len,
	                               // [21:14] payload_byte, [27:22] byte_index
	output logic        m_tlast,   // last
	// configuration
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import fdx_pkg::*;

	localparam int AW = $clog2(MAX_FRAME);
	localparam int WPW = $clog2(MAX_FRAME + 1);

	localparam logic [2:0] PH_SOH  = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_STX  = 3'd2;
	localparam logic [2:0] PH_BODY = 3'd3;
	localparam logic [2:0] PH_EOT  = 3'd4;
	localparam logic [2:0] PH_EMIT = 3'd5;

	logic [6:0]     min_len_q, max_len_q;
	logic [2:0]     phase_q;
	logic [WPW-1:0] wpos_q;
	logic [7:0]     remain_q, flen_q, xor_q, type_q, plen_q, cnt_q;
	logic           m_valid_q, out_last_q, out_zero_q;
	logic [7:0]     out_type_q;
	logic [5:0]     out_plen_q, out_idx_q;

	logic           s_accept, len_ok, keep, frame_ok, issue, is_last;
	logic [AW-1:0]  wr_addr, rd_addr;
	logic [7:0]     rd_data, ovh, plen_next, n_items;
	logic [8:0]     pos;
	fdx_mem_ctl_t   mem_ctl;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_LEN) ? {25'd0, max_len_q} : {25'd0, min_len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= 7'd8;
			max_len_q <= 7'd64;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_MIN_LEN: min_len_q <= pwdata[6:0];
				REG_MAX_LEN: max_len_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// input side decode
	assign s_tready = (phase_q != PH_EMIT);
	assign s_accept = s_tvalid && s_tready;

	assign len_ok = (s_tdata >= MIN_HDR_LEN) && (s_tdata >= {1'b0, min_len_q}) &&
		(s_tdata <= {1'b0, max_len_q}) && ({1'b0, s_tdata} <= 9'(MAX_FRAME));

	always_comb begin
		case (phase_q)
			PH_SOH:  keep = (s_tdata == SOH_BYTE);
			PH_LEN:  keep = len_ok;
			PH_STX:  keep = (s_tdata == STX_BYTE);
			PH_BODY: keep = 1'b1;
			PH_EOT:  keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	assign wr_addr = (phase_q == PH_SOH) ? '0 : wpos_q[AW-1:0];
	assign mem_ctl.wr_en = s_accept && keep &&
		((phase_q == PH_SOH) || ({1'b0, wpos_q} < (WPW + 1)'(MAX_FRAME)));

	// checksum: xor of every kept byte before EOT must be zero
	assign frame_ok = (s_tdata == EOT_BYTE) && (xor_q == 8'h00);

	// payload length uses an overhead of at least five
	assign ovh = ({1'b0, min_len_q} < MIN_HDR_LEN) ? MIN_HDR_LEN : {1'b0, min_len_q};
	assign plen_next = flen_q - ovh;

	// emission: one memory read per issue, read register is the output register
	assign n_items = (plen_q == 8'd0) ? 8'd1 : plen_q;
	assign is_last = (cnt_q == n_items - 8'd1);
	assign issue = (phase_q == PH_EMIT) && (!m_valid_q || m_tready);
	assign pos = 9'(PAYLOAD_POS) + {1'b0, cnt_q};
	assign rd_addr = pos[AW-1:0];
	assign mem_ctl.rd_en = issue;

	fdx_frame_store #(
		.DEPTH(MAX_FRAME),
		.AW(AW)
	) u_store (
		.clk(clk),
		.ctl(mem_ctl),
		.wr_addr(wr_addr),
		.wr_data(s_tdata),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// running checksum and type byte capture
	always_ff @(posedge clk) begin
		if (mem_ctl.wr_en) begin
			xor_q <= (phase_q == PH_SOH) ? s_tdata : (xor_q ^ s_tdata);
			if (wr_addr == AW'(TYPE_POS)) begin
				type_q <= s_tdata;
			end
		end
	end

	// frame state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SOH;
			wpos_q   <= '0;
			remain_q <= '0;
			flen_q   <= '0;
			plen_q   <= '0;
			cnt_q    <= '0;
		end else begin
			if (mem_ctl.wr_en) begin
				wpos_q <= (phase_q == PH_SOH) ? WPW'(1) : wpos_q + WPW'(1);
			end
			unique case (phase_q)
				PH_SOH: begin
					if (s_accept && keep) begin
						phase_q <= PH_LEN;
					end
				end
				PH_LEN: begin
					if (s_accept) begin
						if (len_ok) begin
							flen_q   <= s_tdata;
							remain_q <= s_tdata - 8'd4;
							phase_q  <= PH_STX;
						end else begin
							phase_q <= PH_SOH;
							wpos_q  <= '0;
						end
					end
				end
				PH_STX: begin
					if (s_accept) begin
						if (keep) begin
							phase_q <= PH_BODY;
						end else begin
							phase_q <= PH_SOH;
							wpos_q  <= '0;
						end
					end
				end
				PH_BODY: begin
					if (s_accept) begin
						remain_q <= remain_q - 8'd1;
						if (remain_q == 8'd1) begin
							phase_q <= PH_EOT;
						end
					end
				end
				PH_EOT: begin
					if (s_accept) begin
						wpos_q <= '0;
						if (frame_ok) begin
							plen_q  <= plen_next;
							cnt_q   <= '0;
							phase_q <= PH_EMIT;
						end else begin
							phase_q <= PH_SOH;
						end
					end
				end
				PH_EMIT: begin
					if (issue) begin
						cnt_q <= cnt_q + 8'd1;
						if (is_last) begin
							phase_q <= PH_SOH;
						end
					end
				end
				default: begin
					phase_q <= PH_SOH;
					wpos_q  <= '0;
				end
			endcase
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (issue) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output side fields, loaded with the memory read
	always_ff @(posedge clk) begin
		if (issue) begin
			out_type_q <= type_q;
			out_plen_q <= plen_q[5:0];
			out_idx_q  <= (plen_q == 8'd0) ? 6'd0 : cnt_q[5:0];
			out_zero_q <= (plen_q == 8'd0) || (pos >= 9'(MAX_FRAME));
			out_last_q <= is_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {4'd0, out_idx_q, (out_zero_q ? 8'd0 : rd_data), out_plen_q,
		out_type_q};

`ifndef SYNTH
	// no input is taken while a frame is being replayed
	a_no_input_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EMIT) |-> !s_tready)
		else $error("input accepted during emission");

	// emission counter stays inside the frame's result count
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EMIT) |-> (cnt_q < n_items))
		else $error("emission counter out of range");

	// store position never passes the memory depth
	a_wpos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, wpos_q} <= (WPW + 1)'(MAX_FRAME)))
		else $error("write position beyond frame store");

	// a wrong end byte never starts an emission
	a_bad_eot: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && (phase_q == PH_EOT) && (s_tdata != EOT_BYTE)) |=>
		(phase_q == PH_SOH))
		else $error("frame without EOT emitted");
`endif

endmodule

`default_nettype wire

// File: sim/framed_byte_deframer_xor_check_unit_tb.sv
// framed_byte_deframer_xor_check_unit_tb: self-checking bench for the framed byte deframer
// depends on fdx_pkg and framed_byte_deframer_xor_check_unit; streams good and broken frames
// under several length settings and checks each payload transaction against a frame predictor
`timescale 1ns / 1ps

import fdx_pkg::*;

localparam int FRAME_DEPTH = 64;

typedef enum logic [2:0] {HUNT_SOH, GET_LEN, GET_STX, GET_BODY, GET_EOT} rx_phase_e;

typedef struct {
	logic [7:0] msg_type;
	logic [5:0] payload_len;
	logic [7:0] payload_byte;
	logic [5:0] byte_index;
	logic       last;
} payload_result_t;

// frame predictor plus the queue of payload transactions it expects
class payload_scoreboard;
	logic [6:0]      min_len;
	logic [6:0]      max_len;
	rx_phase_e       phase;
	int unsigned     wr_pos;
	int unsigned     body_left;
	int unsigned     frame_len;
	logic [7:0]      frame_bytes [FRAME_DEPTH];
	payload_result_t expected_payload_q [$];
	int unsigned     errors;
	int unsigned     results_seen;

	function new();
		min_len = 7'd8;
		max_len = 7'd64;
		phase = HUNT_SOH;
		wr_pos = 0;
		body_left = 0;
		frame_len = 0;
		errors = 0;
		results_seen = 0;
		foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
	endfunction

	function void set_reg(logic idx, logic [31:0] word);
		if (idx == REG_MIN_LEN) begin
			min_len = word[6:0];
		end else if (idx == REG_MAX_LEN) begin
			max_len = word[6:0];
		end
	endfunction

	function void keep_byte(logic [7:0] b);
		if (wr_pos < FRAME_DEPTH) begin
			frame_bytes[wr_pos] = b;
			wr_pos++;
		end
	endfunction

	// advance the frame hunt by one accepted byte, queue payload for a good frame
	function void note_rx_byte(logic [7:0] b);
		logic [7:0]      sum;
		int unsigned     ovh;
		int unsigned     plen;
		int unsigned     n;
		payload_result_t r;
		case (phase)
			HUNT_SOH: begin
				if (b == SOH_BYTE) begin
					wr_pos = 0;
					keep_byte(b);
					phase = GET_LEN;
				end
			end
			GET_LEN: begin
				if (b < MIN_HDR_LEN || b < min_len || b > max_len || b > FRAME_DEPTH) begin
					phase = HUNT_SOH;
					wr_pos = 0;
				end else begin
					frame_len = 32'(b);
					body_left = b - 4;
					keep_byte(b);
					phase = GET_STX;
				end
			end
			GET_STX: begin
				if (b != STX_BYTE) begin
					phase = HUNT_SOH;
					wr_pos = 0;
				end else begin
					keep_byte(b);
					phase = GET_BODY;
				end
			end
			GET_BODY: begin
				keep_byte(b);
				body_left = (body_left - 1) & 8'hFF;
				if (body_left == 0) phase = GET_EOT;
			end
			GET_EOT: begin
				keep_byte(b);
				phase = HUNT_SOH;
				wr_pos = 0;
				if (b == EOT_BYTE) begin
					sum = 8'h00;
					for (int unsigned i = 0; i + 2 < frame_len; i++) sum ^= frame_bytes[i];
					// checksum good: one transaction per payload byte, at least one
					if (sum == frame_bytes[frame_len - 2]) begin
						ovh = (min_len < MIN_HDR_LEN) ? 32'(MIN_HDR_LEN) : 32'(min_len);
						plen = frame_len - ovh;
						n = (plen == 0) ? 1 : plen;
						for (int unsigned i = 0; i < n; i++) begin
							r.msg_type = frame_bytes[TYPE_POS];
							r.payload_len = plen[5:0];
							r.payload_byte = (plen != 0 && PAYLOAD_POS + i < FRAME_DEPTH) ?
								frame_bytes[PAYLOAD_POS + i] : 8'h00;
							r.byte_index = (plen != 0) ? i[5:0] : 6'd0;
							r.last = (i + 1 == n);
							expected_payload_q.push_back(r);
						end
					end
				end
			end
			default: begin
				phase = HUNT_SOH;
				wr_pos = 0;
			end
		endcase
	endfunction

	function void check_field(string name, int unsigned exp_val, int unsigned act_val);
		if (exp_val != act_val) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
		end
	endfunction

	// compare one result transaction with the oldest expected payload entry
	function void check_payload_result(logic [31:0] data, logic tl);
		payload_result_t e;
		results_seen++;
		if (expected_payload_q.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none actual data %h last %b",
				$time, data, tl);
			return;
		end
		e = expected_payload_q.pop_front();
		check_field("msg_type", 32'(e.msg_type), 32'(data[7:0]));
		check_field("payload_len", 32'(e.payload_len), 32'(data[13:8]));
		check_field("payload_byte", 32'(e.payload_byte), 32'(data[21:14]));
		check_field("byte_index", 32'(e.byte_index), 32'(data[27:22]));
		check_field("tdata pad", 32'd0, 32'(data[31:28]));
		check_field("last", 32'(e.last), 32'(tl));
	endfunction
endclass

module framed_byte_deframer_xor_check_unit_tb;

	localparam int CLK_PERIOD    = 4;
	localparam int RESET_CYCLES  = 8;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_AFTER    = 12;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int PHASE_BYTES   = 35;

	typedef enum {FR_GOOD, FR_BAD_LEN, FR_BAD_STX, FR_BAD_SUM, FR_BAD_EOT, FR_CUT} frame_kind_e;
	typedef enum {RDY_ALWAYS, RDY_SKIP, RDY_RANDOM, RDY_SPARSE} stall_mode_e;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = 3'd0;
	logic [31:0] pwdata   = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	payload_scoreboard sb = new();

	int unsigned bytes_sent = 0;
	int unsigned burst_left = 0;

	framed_byte_deframer_xor_check_unit #(
		.MAX_FRAME(FRAME_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// result side: check each transaction, stall on a shifting pattern, one long hold-off
	int unsigned rx_tick = 0;
	int unsigned stall_period = 2;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	stall_mode_e stall_mode = RDY_ALWAYS;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_payload_result(m_tdata, m_tlast);
		rx_tick++;
		if (rx_tick % 50 == 0) begin
			stall_mode = stall_mode_e'($urandom_range(0, 3));
			stall_period = $urandom_range(2, 6);
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!hold_done && sb.results_seen >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			case (stall_mode)
				RDY_ALWAYS: m_tready <= 1'b1;
				RDY_SKIP:   m_tready <= (rx_tick % stall_period) != 0;
				RDY_RANDOM: m_tready <= 1'($urandom_range(0, 1));
				default:    m_tready <= (rx_tick % stall_period) == 0;
			endcase
		end
	end

	// watchdog
	int unsigned cycle_count = 0;

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// one byte transaction, sender works in bursts with random gaps
	task automatic send_byte(input logic [7:0] value);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
		end
		burst_left--;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		sb.note_rx_byte(value);
	endtask

	// drop valid and wait until every expected payload transaction has arrived
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.expected_payload_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write: setup phase, access phase, then back to idle
	task automatic write_reg(input logic idx, input logic [6:0] value);
		logic [31:0] word;
		word = $urandom();
		word[6:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, word);
		@(posedge clk);
	endtask

	// finish any open frame, let the block go idle, then load both length limits
	task automatic configure(input logic [6:0] min_val, input logic [6:0] max_val);
		while (sb.phase != HUNT_SOH) send_byte(8'h00);
		wait_idle();
		write_reg(REG_MIN_LEN, min_val);
		write_reg(REG_MAX_LEN, max_val);
	endtask

	function automatic void len_bounds(output int unsigned lo, output int unsigned hi);
		lo = (sb.min_len < MIN_HDR_LEN) ? 32'(MIN_HDR_LEN) : 32'(sb.min_len);
		hi = (sb.max_len > FRAME_DEPTH) ? FRAME_DEPTH : 32'(sb.max_len);
	endfunction

	// mostly short legal lengths, some across the whole legal range
	function automatic int unsigned pick_len();
		int unsigned lo;
		int unsigned hi;
		len_bounds(lo, hi);
		if (lo > hi) return $urandom_range(MIN_HDR_LEN, FRAME_DEPTH);
		if ($urandom_range(0, 4) != 0) return $urandom_range(lo, (hi < lo + 6) ? hi : lo + 6);
		return $urandom_range(lo, hi);
	endfunction

	function automatic int unsigned pick_bad_len();
		int unsigned lo;
		int unsigned hi;
		len_bounds(lo, hi);
		if ($urandom_range(0, 1) != 0) return $urandom_range(0, lo - 1);
		return $urandom_range(hi + 1, 255);
	endfunction

	function automatic logic [7:0] random_byte_except(input logic [7:0] avoid);
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == avoid);
		return b;
	endfunction

	// build a frame with a correct checksum, then break it as the kind asks
	task automatic send_frame(input frame_kind_e kind, input int unsigned flen, input int fill);
		logic [7:0]  fb [FRAME_DEPTH];
		logic [7:0]  sum;
		int unsigned n;
		fb[0] = SOH_BYTE;
		fb[1] = flen[7:0];
		fb[2] = STX_BYTE;
		for (int unsigned i = 3; i + 2 < flen; i++)
			fb[i] = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
		sum = 8'h00;
		for (int unsigned i = 0; i + 2 < flen; i++) sum ^= fb[i];
		fb[flen - 2] = sum;
		fb[flen - 1] = EOT_BYTE;
		n = flen;
		case (kind)
			FR_BAD_LEN: begin
				fb[1] = 8'(pick_bad_len());
				n = 2;
			end
			FR_BAD_STX: begin
				fb[2] = random_byte_except(STX_BYTE);
				n = 3;
			end
			FR_BAD_SUM: fb[flen - 2] = fb[flen - 2] ^ (8'h01 << $urandom_range(0, 7));
			FR_BAD_EOT: begin
				// a stray start byte in the end position must not open a new frame
				fb[flen - 1] = ($urandom_range(0, 1) != 0) ? SOH_BYTE :
					random_byte_except(EOT_BYTE);
			end
			FR_CUT: n = $urandom_range(1, flen - 1);
			default: ;
		endcase
		for (int unsigned i = 0; i < n; i++) send_byte(fb[i]);
	endtask

	// mostly good frames with random content, the rest broken frames and line noise
	task automatic send_random(input int unsigned budget);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned k;
		stop_at = bytes_sent + budget;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				k = $urandom_range(1, 4);
				repeat (k) send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 68) begin
				send_frame(FR_GOOD, pick_len(), -1);
			end else if (pick < 74) begin
				send_frame(FR_BAD_LEN, pick_len(), -1);
			end else if (pick < 80) begin
				send_frame(FR_BAD_STX, pick_len(), -1);
			end else if (pick < 87) begin
				send_frame(FR_BAD_SUM, pick_len(), -1);
			end else if (pick < 93) begin
				send_frame(FR_BAD_EOT, pick_len(), -1);
			end else begin
				send_frame(FR_CUT, pick_len(), -1);
			end
		end
	endtask

	// main sequence
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default limits, written explicitly
		configure(7'd8, 7'd64);
		send_byte(8'h00);
		send_byte(8'hFF);
		// start byte as length is rejected and not taken as a new start
		send_byte(SOH_BYTE);
		send_byte(SOH_BYTE);
		// zero payload length, all-zero content
		send_frame(FR_GOOD, 8, 0);
		send_frame(FR_BAD_STX, 8, -1);
		send_frame(FR_GOOD, 9, 8'hFF);
		send_random(PHASE_BYTES);

		// shortest frames and the longest payload
		configure(7'd5, 7'd64);
		send_frame(FR_GOOD, 5, -1);
		send_frame(FR_BAD_SUM, 5, -1);
		send_frame(FR_BAD_EOT, 5, -1);
		send_frame(FR_GOOD, 64, -1);
		send_random(PHASE_BYTES);

		configure(7'd64, 7'd64);
		send_random(PHASE_BYTES);

		// overhead below five is clamped, lengths over the store depth rejected
		configure(7'd0, 7'd127);
		send_frame(FR_GOOD, 6, -1);
		send_frame(FR_BAD_LEN, 6, -1);
		send_random(PHASE_BYTES);

		configure(7'd5, 7'd8);
		send_random(PHASE_BYTES);

		// no legal length at all
		configure(7'd127, 7'd0);
		send_random(30);

		configure(7'd20, 7'd40);
		send_random(PHASE_BYTES);

		wait_idle();
		if (sb.errors == 0 && sb.expected_payload_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
